// File: rtl/core/lesf_pkg.sv
// shared types, constants and helpers for the largest empty square finder
package lesf_pkg;

  localparam int unsigned CharW       = 8;
  localparam int unsigned SizeW       = 11;
  localparam int unsigned PosW        = 10;
  localparam int unsigned DefMaxCols  = 1024;
  localparam int unsigned DefMaxRows  = 1024;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned InDataW     = 8;
  localparam int unsigned OutDataW    = 32;

  localparam logic [SizeW-1:0] SizeMax       = {SizeW{1'b1}};
  localparam logic [CharW-1:0] EmptyCharRst  = 8'd46;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEmpty    = 1'b0,
    CfgObstacle = 1'b1
  } cfg_idx_e;

  // one cell on its way from the address stage to the scoring stage
  typedef struct packed {
    logic            is_empty;
    logic            border;    // first row or first column
    logic            line_end;
    logic            map_end;
    logic [PosW-1:0] col;
    logic [PosW-1:0] row;
  } cell_t;

  typedef struct packed {
    logic [SizeW-1:0] size;
    logic [PosW-1:0]  col;
    logic [PosW-1:0]  row;
  } result_t;

  function automatic logic [SizeW-1:0] min3(input logic [SizeW-1:0] a,
                                            input logic [SizeW-1:0] b,
                                            input logic [SizeW-1:0] c);
    logic [SizeW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

// File: rtl/core/lesf_line_buf.sv
// line buffer of square sizes from the row above, registered read with write bypass
module lesf_line_buf #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic                      clk_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [lesf_pkg::SizeW-1:0] wdata_i,
  output logic [lesf_pkg::SizeW-1:0] rdata_o
);
  import lesf_pkg::*;

  logic [SizeW-1:0] mem [Depth];
  logic [SizeW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // a read of the entry written in the same cycle sees the new word
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= (we_i && (waddr_i == raddr_i)) ? wdata_i : mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/lesf_score.sv
// scoring stage: square size of a cell, neighbour sizes and best square so far
module lesf_score (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  lesf_pkg::cell_t            cell_i,
  input  logic [lesf_pkg::SizeW-1:0] up_i,
  output logic [lesf_pkg::SizeW-1:0] size_o,
  output lesf_pkg::result_t          result_o
);
  import lesf_pkg::*;

  logic [SizeW-1:0] left_q, left_d;
  logic [SizeW-1:0] upleft_q, upleft_d;
  result_t          best_q, best_d;
  logic [SizeW-1:0] min_nb;
  logic [SizeW-1:0] size;
  logic             better;

  always_comb begin
    min_nb = min3(up_i, upleft_q, left_q);
    if (!cell_i.is_empty) begin
      size = '0;
    end else if (cell_i.border) begin
      size = SizeW'(1);
    end else if (min_nb == SizeMax) begin
      size = SizeMax;
    end else begin
      size = min_nb + SizeW'(1);
    end
  end

  assign better = size > best_q.size;

  always_comb begin
    result_o = best_q;
    if (better) begin
      result_o = '{size: size, col: cell_i.col, row: cell_i.row};
    end
  end

  always_comb begin
    left_d   = left_q;
    upleft_d = upleft_q;
    best_d   = best_q;
    if (adv_i) begin
      left_d   = size;
      upleft_d = up_i;
      best_d   = result_o;
      if (cell_i.line_end || cell_i.map_end) begin
        left_d   = '0;
        upleft_d = '0;
      end
      if (cell_i.map_end) begin
        best_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      upleft_q <= '0;
      best_q   <= '0;
    end else begin
      left_q   <= left_d;
      upleft_q <= upleft_d;
      best_q   <= best_d;
    end
  end

  assign size_o = size;

endmodule

// File: rtl/core/largest_empty_square_finder.sv
// largest empty square finder: a map-end word passes the address-stage and output registers
// to the result word; throughput one cell word per cycle while not stalled; the line buffer
// is read as a word comes in and written by the scoring stage, bypassed for the same column
// the input stalls only while a finished result waits in the output register
// reset clears counters, neighbour sizes, best square and sets the empty code to 46;
// the line buffer is not cleared, the first row of each map ignores what it reads
module largest_empty_square_finder #(
  parameter int unsigned MAX_COLS = lesf_pkg::DefMaxCols,
  parameter int unsigned MAX_ROWS = lesf_pkg::DefMaxRows
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lesf_pkg::InDataW-1:0]  s_axis_tdata,   // [7:0] cell_char
  input  logic                          s_axis_tlast,   // map_end
  input  logic                          s_axis_tuser,   // [0] row_end
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lesf_pkg::OutDataW-1:0] m_axis_tdata,   // [10:0] best_size,
                                                        // [20:11] best_col,
                                                        // [30:21] best_row, [31] zero
  input  logic                          cfg_we_i,
  input  logic [lesf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lesf_pkg::CharW-1:0]    cfg_wdata_i
);
  import lesf_pkg::*;

  localparam int unsigned ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [ColW-1:0] ColLast = ColW'(MAX_COLS - 1);
  localparam logic [RowW-1:0] RowLast = RowW'(MAX_ROWS - 1);

  logic [CharW-1:0] empty_q, empty_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic             s1_valid_q, s1_valid_d;
  cell_t            s1_cell_q, s1_cell_d;
  logic [ColW-1:0]  s1_addr_q;
  logic             out_valid_q, out_valid_d;
  result_t          out_q, out_d;

  logic             in_acc;
  logic             s1_adv;
  logic             out_load;
  logic [SizeW-1:0] up;
  logic [SizeW-1:0] size;
  result_t          result;

  // configuration; the obstacle code needs no storage since any non-empty byte scores zero
  always_comb begin
    empty_d = empty_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgEmpty:    empty_d = cfg_wdata_i;
        CfgObstacle: empty_d = empty_q;
        default:     empty_d = empty_q;
      endcase
    end
  end

  assign s1_adv = s1_valid_q &&
                  !(s1_cell_q.map_end && out_valid_q && !m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_load = s1_adv && s1_cell_q.map_end;

  // address stage: column and row counters and the cell word for the scoring stage
  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    s1_cell_d  = s1_cell_q;
    s1_valid_d = s1_valid_q;
    if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (in_acc) begin
      s1_valid_d = 1'b1;
      s1_cell_d  = '{is_empty: s_axis_tdata[CharW-1:0] == empty_q,
                     border:   (row_q == '0) || (col_q == '0),
                     line_end: s_axis_tuser,
                     map_end:  s_axis_tlast,
                     col:      PosW'(col_q),
                     row:      PosW'(row_q)};
      if (col_q < ColLast) begin
        col_d = col_q + ColW'(1);
      end
      if (s_axis_tuser || s_axis_tlast) begin
        col_d = '0;
        if (row_q < RowLast) begin
          row_d = row_q + RowW'(1);
        end
      end
      if (s_axis_tlast) begin
        row_d = '0;
      end
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q     <= EmptyCharRst;
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      empty_q     <= empty_d;
      col_q       <= col_d;
      row_q       <= row_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cell_q <= s1_cell_d;
    out_q     <= out_d;
    if (in_acc) begin
      s1_addr_q <= col_q;
    end
  end

  lesf_line_buf #(
    .Depth (MAX_COLS),
    .AddrW (ColW)
  ) u_line_buf (
    .clk_i   (clk_i),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .we_i    (s1_adv),
    .waddr_i (s1_addr_q),
    .wdata_i (size),
    .rdata_o (up)
  );

  lesf_score u_score (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (s1_adv),
    .cell_i   (s1_cell_q),
    .up_i     (up),
    .size_o   (size),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'({out_q.row, out_q.col, out_q.size});

  // a result word only appears right after a map-end cell left the scoring stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s1_adv && s1_cell_q.map_end))
    else $error("result word without a map-end cell");

  // no square means no position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_q.size == '0)) |-> (out_q.col == '0 && out_q.row == '0))
    else $error("empty result carries a position");

  // a map-end cell restarts counting at the top-left corner
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> (col_q == '0 && row_q == '0))
    else $error("counters not cleared after map end");

endmodule
